>>> design/bgfl_pkg.sv
package bgfl_pkg;

   localparam logic MODE_CLAIM = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_OOM   = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_GROW,
      ST_FETCH
   } state_type;

   typedef struct packed {
      logic capture;
      logic rd_en;
      logic start_grow;
      logic sweep;
      logic grow_commit;
      logic apply;
   } cmd_type;

   typedef struct packed {
      logic mode;
      logic head_valid;
      logic full;
      logic sweep_last;
      logic rsp_free;
   } status_type;

endpackage

>>> design/block_growing_free_list_allocator.sv
// Slot allocator over a pool that grows one block of SLOTS_PER_BLOCK slots at a time,
// up to MAX_BLOCKS blocks. Free slots form a LIFO list kept in a link memory.
// Request channel (req_*): mode 0 claims a slot, mode 1 returns req_free_index.
// Result channel (rsp_*): one result per request, in order: granted slot (zero
// unless a claim succeeds), status (ok, out of memory, freed index out of range)
// and the number of blocks in use after the request.
// The result register is loaded after the request transfer: the link memory is read
// at the list head on the transfer edge, and the update is applied in the execute state.
// A claim that finds the list empty adds a block first, unless MAX_BLOCKS are already
// in use, writing its links one slot a cycle.
// One request is in work at a time; the next is taken in the cycle after the result is
// loaded, while that result may still wait in the output register.
// After reset block zero is chained through the single link memory port with
// req_ready low; then one block is in use and the head is its top slot.
// If the receiver stalls, a finished result holds in the output register, and a
// following request waits before its update until that register is free.
module block_growing_free_list_allocator #(
   parameter int SLOTS_PER_BLOCK = 64,
   parameter int MAX_BLOCKS      = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_mode,
   input  logic [9:0] req_free_index,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [9:0] rsp_granted_index,
   output logic [1:0] rsp_status,
   output logic [4:0] rsp_blocks_in_use
);
   import bgfl_pkg::*;

   cmd_type    dp_cmd;
   status_type dp_status;

   bgfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   bgfl_dpath #(
      .SLOTS_PER_BLOCK (SLOTS_PER_BLOCK),
      .MAX_BLOCKS      (MAX_BLOCKS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_mode          (req_mode),
      .req_free_index    (req_free_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_granted_index (rsp_granted_index),
      .rsp_status        (rsp_status),
      .rsp_blocks_in_use (rsp_blocks_in_use),
      .dp_cmd            (dp_cmd),
      .dp_status         (dp_status)
   );

endmodule

>>> design/bgfl_ctrl.sv
module bgfl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bgfl_pkg::status_type dp_status,
   output bgfl_pkg::cmd_type    dp_cmd
);
   import bgfl_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      need_grow;

   assign need_grow = (dp_status.mode == MODE_CLAIM) && !dp_status.head_valid &&
                      !dp_status.full;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (dp_status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (need_grow) begin
               state_in = ST_GROW;
            end else if (dp_status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_GROW: begin
            if (dp_status.sweep_last) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_EXEC;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_comb begin
      dp_cmd    = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_INIT: begin
            dp_cmd.sweep = 1'b1;
         end
         ST_IDLE: begin
            req_ready      = 1'b1;
            dp_cmd.capture = req_valid;
            dp_cmd.rd_en   = req_valid;
         end
         ST_EXEC: begin
            dp_cmd.start_grow = need_grow;
            dp_cmd.apply      = !need_grow && dp_status.rsp_free;
         end
         ST_GROW: begin
            dp_cmd.sweep       = 1'b1;
            dp_cmd.grow_commit = dp_status.sweep_last;
         end
         ST_FETCH: begin
            dp_cmd.rd_en = 1'b1;
         end
         default: begin
            dp_cmd = '0;
         end
      endcase
   end

   a_apply_needs_room: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.apply |-> dp_status.rsp_free)
      else $error("result loaded while the output register is occupied");

   a_grow_only_when_empty: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.start_grow |-> !dp_status.head_valid && !dp_status.full)
      else $error("block added while the free list is not empty");

   a_fetch_follows_grow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GROW) && dp_status.sweep_last |=> (state_ff == ST_FETCH))
      else $error("grow sweep did not end in a head fetch");

endmodule

>>> design/bgfl_dpath.sv
module bgfl_dpath #(
   parameter int SLOTS_PER_BLOCK,
   parameter int MAX_BLOCKS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_mode,
   input  logic [9:0]           req_free_index,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [9:0]           rsp_granted_index,
   output logic [1:0]           rsp_status,
   output logic [4:0]           rsp_blocks_in_use,
   input  bgfl_pkg::cmd_type    dp_cmd,
   output bgfl_pkg::status_type dp_status
);
   import bgfl_pkg::*;

   localparam int TOTAL = SLOTS_PER_BLOCK * MAX_BLOCKS;
   localparam int IW    = $clog2(TOTAL);
   localparam int KW    = $clog2(SLOTS_PER_BLOCK);
   localparam int UW    = $clog2(TOTAL + 1);
   localparam int BW    = $clog2(MAX_BLOCKS + 1);
   localparam int CW    = (UW > 10) ? UW : 10;
   localparam int GW    = (IW > 10) ? IW : 10;
   localparam int OW    = (BW > 5) ? BW : 5;

   logic [IW:0]   link_mem [TOTAL];
   logic [IW:0]   rd_data_ff;

   logic          head_valid_ff;
   logic [IW-1:0] head_idx_ff;
   logic [BW-1:0] block_count_ff;
   logic [UW-1:0] used_slots_ff;
   logic [UW-1:0] base_ff;
   logic [KW-1:0] k_ff;

   logic          mode_ff;
   logic [9:0]    idx_ff;

   logic          rsp_valid_ff;
   logic [9:0]    rsp_granted_ff;
   logic [1:0]    rsp_status_ff;
   logic [4:0]    rsp_blocks_ff;

   logic [IW-1:0] sweep_addr;
   logic [IW:0]   sweep_data;
   logic [CW-1:0] idx_ext;
   logic          idx_ok;
   logic          sweep_last;
   logic          claim_ok;
   logic          free_ok;
   logic [GW-1:0] granted_ext;
   logic [OW-1:0] blocks_ext;
   logic [BW-1:0] blocks_next;

   assign sweep_addr  = base_ff[IW-1:0] + IW'(k_ff);
   assign sweep_data  = (k_ff == '0) ? '0 : {1'b1, sweep_addr - IW'(1)};
   assign sweep_last  = (k_ff == KW'(SLOTS_PER_BLOCK - 1));
   assign idx_ext     = CW'(idx_ff);
   assign idx_ok      = idx_ext < CW'(used_slots_ff);
   assign claim_ok    = (mode_ff == MODE_CLAIM) && head_valid_ff;
   assign free_ok     = (mode_ff == MODE_FREE) && idx_ok;
   assign granted_ext = GW'(head_idx_ff);
   assign blocks_next = block_count_ff;
   assign blocks_ext  = OW'(blocks_next);

   assign dp_status.mode       = mode_ff;
   assign dp_status.head_valid = head_valid_ff;
   assign dp_status.full       = (block_count_ff == BW'(MAX_BLOCKS));
   assign dp_status.sweep_last = sweep_last;
   assign dp_status.rsp_free   = !rsp_valid_ff || rsp_ready;

   // link memory
   always_ff @(posedge clock) begin
      if (dp_cmd.sweep) begin
         link_mem[sweep_addr] <= sweep_data;
      end else if (dp_cmd.apply && free_ok) begin
         link_mem[idx_ext[IW-1:0]] <= {head_valid_ff, head_idx_ff};
      end
      if (dp_cmd.rd_en) begin
         rd_data_ff <= link_mem[head_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         mode_ff <= req_mode;
         idx_ff  <= req_free_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff  <= 1'b1;
         head_idx_ff    <= IW'(SLOTS_PER_BLOCK - 1);
         block_count_ff <= BW'(1);
         used_slots_ff  <= UW'(SLOTS_PER_BLOCK);
         base_ff        <= '0;
         k_ff           <= '0;
      end else begin
         if (dp_cmd.start_grow) begin
            base_ff <= used_slots_ff;
            k_ff    <= '0;
         end else if (dp_cmd.sweep) begin
            k_ff <= sweep_last ? '0 : k_ff + KW'(1);
         end
         if (dp_cmd.grow_commit) begin
            block_count_ff <= block_count_ff + BW'(1);
            used_slots_ff  <= used_slots_ff + UW'(SLOTS_PER_BLOCK);
            head_valid_ff  <= 1'b1;
            head_idx_ff    <= sweep_addr;
         end else if (dp_cmd.apply && claim_ok) begin
            head_valid_ff <= rd_data_ff[IW];
            head_idx_ff   <= rd_data_ff[IW-1:0];
         end else if (dp_cmd.apply && free_ok) begin
            head_valid_ff <= 1'b1;
            head_idx_ff   <= idx_ext[IW-1:0];
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dp_cmd.apply) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.apply) begin
         rsp_granted_ff <= claim_ok ? granted_ext[9:0] : 10'd0;
         rsp_blocks_ff  <= blocks_ext[4:0];
         if (mode_ff == MODE_CLAIM) begin
            rsp_status_ff <= head_valid_ff ? STATUS_OK : STATUS_OOM;
         end else begin
            rsp_status_ff <= idx_ok ? STATUS_OK : STATUS_RANGE;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted_index = rsp_granted_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_blocks_in_use = rsp_blocks_ff;

   a_used_matches_blocks: assert property (@(posedge clock) disable iff (reset)
      used_slots_ff == UW'(32'(block_count_ff) * SLOTS_PER_BLOCK))
      else $error("slot limit out of step with block count");

   a_block_count_bounds: assert property (@(posedge clock) disable iff (reset)
      block_count_ff != '0 && block_count_ff <= BW'(MAX_BLOCKS))
      else $error("block count out of bounds");

   a_head_valid_after_grow: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.grow_commit |=> head_valid_ff && (block_count_ff == $past(block_count_ff) + BW'(1)))
      else $error("new block did not become the free-list head");

   a_sweep_no_apply: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.sweep |-> !dp_cmd.apply && !dp_cmd.rd_en && !dp_cmd.capture)
      else $error("link memory port used by a request during a sweep");

endmodule

>>> tb/sv/testbench.sv
module testbench;
   import bgfl_pkg::*;

   localparam int SLOTS      = 64;
   localparam int BLOCKS     = 16;
   localparam int POOL_SLOTS = SLOTS * BLOCKS;
   localparam int IDLE_LIMIT = 2000;

   typedef struct packed {
      logic [9:0] granted;
      logic [1:0] status;
      logic [4:0] blocks;
   } pool_result_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic       req_mode;
   logic [9:0] req_free_index;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [9:0] rsp_granted_index;
   logic [1:0] rsp_status;
   logic [4:0] rsp_blocks_in_use;

   // predicted pool: link per slot, list head, blocks grown so far
   logic         link_ok [POOL_SLOTS];
   logic [9:0]   link_to [POOL_SLOTS];
   logic         head_ok;
   logic [9:0]   head_at;
   int           blocks_used;

   pool_result_type pending[$];
   logic [9:0]      held[$];
   pool_result_type want_rsp;

   logic no_idle;
   int   rsp_wait;
   int   idle_cycles;
   int   errors;
   int   n_checked;
   int   n_claims;
   int   n_frees;
   int   n_oom;
   int   n_range;

   block_growing_free_list_allocator #(
      .SLOTS_PER_BLOCK(SLOTS),
      .MAX_BLOCKS     (BLOCKS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_free_index   (req_free_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_granted_index(rsp_granted_index),
      .rsp_status       (rsp_status),
      .rsp_blocks_in_use(rsp_blocks_in_use)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // new block: slot k links down to slot k-1, lowest slot ends the list
   function automatic void chain_block(int blk);
      int base;
      base = blk * SLOTS;
      link_ok[base] = 1'b0;
      link_to[base] = '0;
      for (int k = 1; k < SLOTS; k++) begin
         link_ok[base + k] = 1'b1;
         link_to[base + k] = 10'(base + k - 1);
      end
   endfunction

   function automatic pool_result_type apply_request(logic mode, logic [9:0] idx);
      pool_result_type r;
      r.granted = '0;
      r.status  = STATUS_OK;
      r.blocks  = '0;
      if (mode == MODE_CLAIM) begin
         if (!head_ok) begin
            if (blocks_used >= BLOCKS) begin
               r.status = STATUS_OOM;
            end else begin
               chain_block(blocks_used);
               blocks_used++;
               head_ok = 1'b1;
               head_at = 10'(blocks_used * SLOTS - 1);
            end
         end
         if (r.status == STATUS_OK) begin
            r.granted = head_at;
            head_ok   = link_ok[head_at];
            head_at   = link_to[head_at];
         end
      end else if (int'(idx) >= blocks_used * SLOTS) begin
         r.status = STATUS_RANGE;
      end else begin
         link_ok[idx] = head_ok;
         link_to[idx] = head_at;
         head_ok      = 1'b1;
         head_at      = idx;
      end
      r.blocks = 5'(blocks_used);
      return r;
   endfunction

   function automatic logic [9:0] pull_held();
      int         pos;
      logic [9:0] slot;
      pos  = $urandom_range(0, held.size() - 1);
      slot = held[pos];
      held.delete(pos);
      return slot;
   endfunction

   task automatic send_request(input logic mode, input logic [9:0] idx);
      int              gap;
      pool_result_type r;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_free_index <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      r = apply_request(mode, idx);
      pending.push_back(r);
      if (mode == MODE_CLAIM) n_claims++;
      else n_frees++;
      if (r.status == STATUS_OOM) n_oom++;
      if (r.status == STATUS_RANGE) n_range++;
      if (mode == MODE_CLAIM && r.status == STATUS_OK) held.push_back(r.granted);
   endtask

   task automatic test_first_claims();
      send_request(MODE_CLAIM, 10'h3FF);
      send_request(MODE_CLAIM, 10'h000);
      send_request(MODE_CLAIM, 10'h155);
      send_request(MODE_FREE, pull_held());
      send_request(MODE_CLAIM, 10'h2AA);
      send_request(MODE_FREE, pull_held());
   endtask

   task automatic test_free_range();
      send_request(MODE_FREE, 10'd64);
      send_request(MODE_FREE, 10'd1023);
      send_request(MODE_FREE, 10'h2AA);
      send_request(MODE_FREE, 10'h155);
      send_request(MODE_FREE, 10'h3C0);
      send_request(MODE_CLAIM, 10'd0);
   endtask

   // mostly well-formed claim/free traffic, some frees past the grown blocks
   task automatic test_mixed_traffic(input int count);
      int roll;
      for (int i = 0; i < count; i++) begin
         no_idle = (i >= count / 3 && i < count / 3 + 100);
         roll = $urandom_range(0, 99);
         if (roll < 60 || held.size() == 0) begin
            send_request(MODE_CLAIM, 10'($urandom_range(0, 1023)));
         end else if (roll < 92) begin
            send_request(MODE_FREE, pull_held());
         end else if (blocks_used < BLOCKS) begin
            send_request(MODE_FREE, 10'($urandom_range(blocks_used * SLOTS, 1023)));
         end else begin
            send_request(MODE_CLAIM, 10'($urandom_range(0, 1023)));
         end
      end
      no_idle = 1'b0;
   endtask

   task automatic test_pool_exhaustion();
      int oom_start;
      oom_start = n_oom;
      while (n_oom - oom_start < 3) send_request(MODE_CLAIM, 10'($urandom_range(0, 1023)));
      for (int i = held.size() - 1; i >= 0; i--) begin
         if (held[i] == 10'd0 || held[i] == 10'd1023) begin
            send_request(MODE_FREE, held[i]);
            held.delete(i);
         end
      end
      repeat (20) send_request(MODE_FREE, pull_held());
      repeat (25) send_request(MODE_CLAIM, 10'($urandom_range(0, 1023)));
   endtask

   // a repeated free is not caught, so the same slot comes back more than once
   task automatic test_double_free();
      logic [9:0] slot;
      slot = pull_held();
      send_request(MODE_FREE, slot);
      send_request(MODE_FREE, slot);
      repeat (3) send_request(MODE_CLAIM, 10'($urandom_range(0, 1023)));
      send_request(MODE_FREE, pull_held());
      repeat (2) send_request(MODE_CLAIM, 10'($urandom_range(0, 1023)));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         n_checked++;
         if (pending.size() == 0) begin
            $error("result transfer with nothing expected");
            errors++;
         end else begin
            want_rsp = pending.pop_front();
            if (rsp_granted_index !== want_rsp.granted) begin
               $error("granted_index: expected %0d, actual %0d",
                      want_rsp.granted, rsp_granted_index);
               errors++;
            end
            if (rsp_status !== want_rsp.status) begin
               $error("status: expected %0d, actual %0d", want_rsp.status, rsp_status);
               errors++;
            end
            if (rsp_blocks_in_use !== want_rsp.blocks) begin
               $error("blocks_in_use: expected %0d, actual %0d",
                      want_rsp.blocks, rsp_blocks_in_use);
               errors++;
            end
         end
         rsp_wait = no_idle ? 0 : $urandom_range(0, 3);
         rsp_ready <= (rsp_wait == 0);
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_ready <= (rsp_wait == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("block_growing_free_list_allocator regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_mode       <= MODE_CLAIM;
      req_free_index <= '0;
      rsp_ready      <= 1'b1;
      no_idle     = 1'b0;
      rsp_wait    = 0;
      idle_cycles = 0;
      errors      = 0;
      n_checked   = 0;
      n_claims    = 0;
      n_frees     = 0;
      n_oom       = 0;
      n_range     = 0;
      for (int i = 0; i < POOL_SLOTS; i++) begin
         link_ok[i] = 1'b0;
         link_to[i] = '0;
      end
      chain_block(0);
      head_ok     = 1'b1;
      head_at     = 10'(SLOTS - 1);
      blocks_used = 1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_first_claims();
      test_free_range();
      test_mixed_traffic(100);
      test_pool_exhaustion();
      test_double_free();
      req_valid <= 1'b0;

      while (pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("sent %0d claims and %0d frees; %0d out-of-memory, %0d out-of-range",
               n_claims, n_frees, n_oom, n_range);
      $display("checked %0d results, pool grown to %0d blocks", n_checked, blocks_used);
      if (errors == 0) begin
         $display("block_growing_free_list_allocator regression: pass");
      end else begin
         $display("block_growing_free_list_allocator regression: fail");
      end
      $finish;
   end

endmodule

>>> block_growing_free_list_allocator.f
design/bgfl_pkg.sv
design/bgfl_ctrl.sv
design/bgfl_dpath.sv
design/block_growing_free_list_allocator.sv
tb/sv/testbench.sv
